>>> hdl/sac_pkg.sv
// Shared types and constants for the set-associative cache model
`timescale 1ns / 1ps

package sac_pkg;

  // address and tag geometry
  localparam int ADDR_W = 32;
  localparam int TAG_W  = 30;

  // result widths
  localparam int COST_W = 18;
  localparam int CNT_W  = 32;
  localparam int CYC_W  = 48;

  // configuration port
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LOG2 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_LOG2   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LRU        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_BACK = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_ALLOC = 3'd4;

  localparam logic [CFG_W-1:0] BBL_MIN   = 4'd2;
  localparam logic [CFG_W-1:0] BBL_MAX   = 4'd12;
  localparam logic [CFG_W-1:0] BBL_RESET = 4'd4;
  localparam int               SCL_RESET = 8;

  // access kind
  localparam logic KIND_STORE = 1'b1;

  // cost model: a fill is (block bytes / 4) * 100 = 25 << block log2
  localparam logic [COST_W-1:0] FILL_UNIT = 18'd25;
  localparam logic [COST_W-1:0] WT_COST   = 18'd100;
  localparam logic [COST_W-1:0] HIT_COST  = 18'd1;

  // one finished access, handed to the statistics block
  typedef struct packed {
    logic              valid;
    logic              store;
    logic              hit;
    logic [COST_W-1:0] cost;
  } stat_upd_t;

endpackage

>>> hdl/sac_set_ram.sv
// Set memory: one row per set holding every way's tag, valid, dirty and rank
`timescale 1ns / 1ps

module sac_set_ram #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8,
  parameter int DATA_W = 136
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata_r
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

>>> hdl/sac_way_scan.sv
// Shared way comparator: walks the ways of a set one per cycle
`timescale 1ns / 1ps

module sac_way_scan #(
  parameter int WAY_W  = 2,
  parameter int RANK_W = 2,
  parameter int VCNT_W = 3
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [WAY_W-1:0]         way_idx,
  input  logic                     ent_valid,
  input  logic [sac_pkg::TAG_W-1:0] ent_tag,
  input  logic [RANK_W-1:0]        ent_rank,
  input  logic [sac_pkg::TAG_W-1:0] key_tag,
  output logic                     hit_r,
  output logic [WAY_W-1:0]         hit_way_r,
  output logic                     inv_found_r,
  output logic [WAY_W-1:0]         inv_way_r,
  output logic [WAY_W-1:0]         min_way_r,
  output logic [VCNT_W-1:0]        vcount_r
);

  logic              first;
  logic              match;
  logic [RANK_W-1:0] min_rank_r;

  assign first = (way_idx == WAY_W'(0));
  assign match = ent_valid && (ent_tag == key_tag);

  // way 0 seeds the running results, later ways refine them
  always_ff @(posedge clk) begin
    if (en) begin
      if (first) begin
        hit_r       <= match;
        hit_way_r   <= way_idx;
        inv_found_r <= !ent_valid;
        inv_way_r   <= way_idx;
        min_way_r   <= way_idx;
        min_rank_r  <= ent_rank;
        vcount_r    <= VCNT_W'(ent_valid);
      end else begin
        if (!hit_r && match) begin
          hit_r     <= 1'b1;
          hit_way_r <= way_idx;
        end
        if (!inv_found_r && !ent_valid) begin
          inv_found_r <= 1'b1;
          inv_way_r   <= way_idx;
        end
        // strict less-than keeps the lowest way on a tie
        if (ent_rank < min_rank_r) begin
          min_rank_r <= ent_rank;
          min_way_r  <= way_idx;
        end
        vcount_r <= vcount_r + VCNT_W'(ent_valid);
      end
    end
  end

endmodule

>>> hdl/sac_stats.sv
// Running access totals and charged-cycle accumulator, all saturating
`timescale 1ns / 1ps

module sac_stats (
  input  logic                      clk,
  input  logic                      rst_n,
  input  sac_pkg::stat_upd_t        upd,
  output logic [sac_pkg::CNT_W-1:0] load_cnt_r,
  output logic [sac_pkg::CNT_W-1:0] store_cnt_r,
  output logic [sac_pkg::CNT_W-1:0] load_hit_cnt_r,
  output logic [sac_pkg::CNT_W-1:0] load_miss_cnt_r,
  output logic [sac_pkg::CNT_W-1:0] store_hit_cnt_r,
  output logic [sac_pkg::CNT_W-1:0] store_miss_cnt_r,
  output logic [sac_pkg::CYC_W-1:0] cyc_total_r
);

  function automatic logic [sac_pkg::CNT_W-1:0] sat_inc(input logic [sac_pkg::CNT_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  logic [sac_pkg::CYC_W:0] cyc_sum;

  assign cyc_sum = {1'b0, cyc_total_r} + (sac_pkg::CYC_W + 1)'(upd.cost);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_cnt_r       <= '0;
      store_cnt_r      <= '0;
      load_hit_cnt_r   <= '0;
      load_miss_cnt_r  <= '0;
      store_hit_cnt_r  <= '0;
      store_miss_cnt_r <= '0;
      cyc_total_r      <= '0;
    end else if (upd.valid) begin
      if (upd.store == sac_pkg::KIND_STORE) begin
        store_cnt_r <= sat_inc(store_cnt_r);
        if (upd.hit) begin
          store_hit_cnt_r <= sat_inc(store_hit_cnt_r);
        end else begin
          store_miss_cnt_r <= sat_inc(store_miss_cnt_r);
        end
      end else begin
        load_cnt_r <= sat_inc(load_cnt_r);
        if (upd.hit) begin
          load_hit_cnt_r <= sat_inc(load_hit_cnt_r);
        end else begin
          load_miss_cnt_r <= sat_inc(load_miss_cnt_r);
        end
      end
      // carry out of the 48-bit sum pins the total at all ones
      cyc_total_r <= cyc_sum[sac_pkg::CYC_W] ? '1 : cyc_sum[sac_pkg::CYC_W-1:0];
    end
  end

endmodule

>>> hdl/set_assoc_cache_model.sv
// Set-associative cache model, top level: sequencer, set row update and ports
//
// An access is taken when start is high and busy is low, and its result word
// is shown for exactly one cycle with out_valid; the receiver cannot stall it.
// From the edge that takes an access to the edge that takes its result, the
// block does one set-memory read, walks the ways one at a time through the single
// shared tag comparator, writes the updated set row back, and then shows the
// result word. busy drops in the cycle out_valid is shown, so a new start can be
// taken there. After reset the set memory is cleared one set per cycle through
// all SETS sets, with busy high; configuration writes are taken at any time but
// should be made only while idle. Totals on the out_*_count ports change only
// with out_valid.
`timescale 1ns / 1ps

module set_assoc_cache_model #(
  parameter int SETS = 256,
  parameter int WAYS = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_kind,
  input  logic [sac_pkg::ADDR_W-1:0]       in_address,
  output logic                             out_valid,
  output logic                             out_hit,
  output logic                             out_dirty_eviction,
  output logic [sac_pkg::COST_W-1:0]       out_access_cycles,
  output logic [sac_pkg::CNT_W-1:0]        out_load_count,
  output logic [sac_pkg::CNT_W-1:0]        out_store_count,
  output logic [sac_pkg::CNT_W-1:0]        out_load_hit_count,
  output logic [sac_pkg::CNT_W-1:0]        out_load_miss_count,
  output logic [sac_pkg::CNT_W-1:0]        out_store_hit_count,
  output logic [sac_pkg::CNT_W-1:0]        out_store_miss_count,
  output logic [sac_pkg::CYC_W-1:0]        out_cycle_total,
  input  logic                             cfg_we,
  input  logic [sac_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sac_pkg::CFG_W-1:0]        cfg_data
);

  localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int RANK_W = WAY_W;
  localparam int VCNT_W = $clog2(WAYS + 1);
  localparam int ENT_W  = sac_pkg::TAG_W + 2 + RANK_W;
  localparam int ROW_W  = WAYS * ENT_W;
  localparam int MAX_SET_LOG2 = $clog2(SETS + 1) - 1;
  localparam int SCL_RST = (sac_pkg::SCL_RESET > MAX_SET_LOG2) ? MAX_SET_LOG2
                                                                : sac_pkg::SCL_RESET;

  // entry layout: tag | valid | dirty | rank
  localparam int VALID_B = RANK_W + 1;
  localparam int DIRTY_B = RANK_W;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_DECIDE
  } state_t;

  state_t state_r;

  // configuration
  logic [sac_pkg::CFG_W-1:0] bbl_r;
  logic [sac_pkg::CFG_W-1:0] scl_r;
  logic                      lru_r;
  logic                      wb_r;
  logic                      walloc_r;

  // access in flight
  logic [SET_W-1:0]          set_r;
  logic [sac_pkg::TAG_W-1:0] key_r;
  logic                      kind_r;
  logic [WAY_W-1:0]          way_cnt_r;
  logic [SET_W-1:0]          clr_cnt_r;

  logic                         out_valid_r;
  logic                         out_hit_r;
  logic                         out_evict_r;
  logic [sac_pkg::COST_W-1:0]   out_cycles_r;

  // address split
  logic [sac_pkg::ADDR_W-1:0] addr_sh;
  logic [sac_pkg::ADDR_W-1:0] set_mask;
  logic [sac_pkg::ADDR_W-1:0] set_full;
  logic [sac_pkg::CFG_W:0]    tag_shift;
  logic [sac_pkg::ADDR_W-1:0] tag_full;

  // memory
  logic             ram_we;
  logic [SET_W-1:0] ram_waddr;
  logic [ROW_W-1:0] ram_wdata;
  logic [ROW_W-1:0] row;
  logic [ROW_W-1:0] new_row;

  logic [ENT_W-1:0] ent_a [WAYS];

  // scan results
  logic              sc_hit;
  logic [WAY_W-1:0]  sc_hit_way;
  logic              sc_inv_found;
  logic [WAY_W-1:0]  sc_inv_way;
  logic [WAY_W-1:0]  sc_min_way;
  logic [VCNT_W-1:0] sc_vcount;

  // decision
  logic                       is_store;
  logic                       do_fill;
  logic                       do_newest;
  logic                       was_valid;
  logic [WAY_W-1:0]           tgt_way;
  logic [RANK_W-1:0]          old_rank;
  logic                       tgt_dirty;
  logic [RANK_W-1:0]          others;
  logic                       evict;
  logic [sac_pkg::COST_W-1:0] fill_cost;
  logic [sac_pkg::COST_W-1:0] wt_extra;
  logic [sac_pkg::COST_W-1:0] cost;

  sac_pkg::stat_upd_t stat_upd;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bbl_r    <= sac_pkg::BBL_RESET;
      scl_r    <= sac_pkg::CFG_W'(SCL_RST);
      lru_r    <= 1'b1;
      wb_r     <= 1'b1;
      walloc_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sac_pkg::CFG_BLOCK_LOG2: begin
          if (cfg_data < sac_pkg::BBL_MIN) begin
            bbl_r <= sac_pkg::BBL_MIN;
          end else if (cfg_data > sac_pkg::BBL_MAX) begin
            bbl_r <= sac_pkg::BBL_MAX;
          end else begin
            bbl_r <= cfg_data;
          end
        end
        sac_pkg::CFG_SET_LOG2: begin
          if (cfg_data > sac_pkg::CFG_W'(MAX_SET_LOG2)) begin
            scl_r <= sac_pkg::CFG_W'(MAX_SET_LOG2);
          end else begin
            scl_r <= cfg_data;
          end
        end
        sac_pkg::CFG_LRU:         lru_r    <= cfg_data[0];
        sac_pkg::CFG_WRITE_BACK:  wb_r     <= cfg_data[0];
        sac_pkg::CFG_WRITE_ALLOC: walloc_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------- address split
  assign addr_sh   = in_address >> bbl_r;
  assign set_mask  = ~({sac_pkg::ADDR_W{1'b1}} << scl_r);
  assign set_full  = addr_sh & set_mask;
  assign tag_shift = {1'b0, bbl_r} + {1'b0, scl_r};
  assign tag_full  = in_address >> tag_shift;

  // ----------------------------------------------------------------- memory
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = set_r;
    ram_wdata = new_row;
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = '0;
    end else if (state_r == ST_DECIDE) begin
      ram_we = 1'b1;
    end
  end

  sac_set_ram #(
    .DEPTH  (SETS),
    .ADDR_W (SET_W),
    .DATA_W (ROW_W)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (state_r == ST_READ),
    .raddr   (set_r),
    .rdata_r (row)
  );

  for (genvar g = 0; g < WAYS; g++) begin : g_unpack
    assign ent_a[g] = row[g*ENT_W +: ENT_W];
  end

  // -------------------------------------------------------------- way scan
  sac_way_scan #(
    .WAY_W  (WAY_W),
    .RANK_W (RANK_W),
    .VCNT_W (VCNT_W)
  ) u_scan (
    .clk         (clk),
    .en          (state_r == ST_SCAN),
    .way_idx     (way_cnt_r),
    .ent_valid   (ent_a[way_cnt_r][VALID_B]),
    .ent_tag     (ent_a[way_cnt_r][ENT_W-1 -: sac_pkg::TAG_W]),
    .ent_rank    (ent_a[way_cnt_r][RANK_W-1:0]),
    .key_tag     (key_r),
    .hit_r       (sc_hit),
    .hit_way_r   (sc_hit_way),
    .inv_found_r (sc_inv_found),
    .inv_way_r   (sc_inv_way),
    .min_way_r   (sc_min_way),
    .vcount_r    (sc_vcount)
  );

  // --------------------------------------------------------------- decision
  assign is_store  = (kind_r == sac_pkg::KIND_STORE);
  assign do_fill   = !sc_hit && (!is_store || walloc_r);
  assign do_newest = (sc_hit && lru_r) || do_fill;
  assign was_valid = sc_hit || !sc_inv_found;
  assign tgt_way   = sc_hit ? sc_hit_way : (sc_inv_found ? sc_inv_way : sc_min_way);
  assign old_rank  = ent_a[tgt_way][RANK_W-1:0];
  assign tgt_dirty = ent_a[tgt_way][DIRTY_B];
  assign others    = RANK_W'(sc_vcount - VCNT_W'(was_valid));
  // a dirty victim is only written back under write-back
  assign evict     = do_fill && !sc_inv_found && tgt_dirty && wb_r;

  assign fill_cost = sac_pkg::FILL_UNIT << bbl_r;
  assign wt_extra  = wb_r ? '0 : sac_pkg::WT_COST;

  always_comb begin
    if (!is_store) begin
      cost = sc_hit ? sac_pkg::HIT_COST : sac_pkg::HIT_COST + fill_cost;
    end else if (sc_hit) begin
      cost = sac_pkg::HIT_COST + wt_extra;
    end else if (walloc_r) begin
      cost = sac_pkg::HIT_COST + fill_cost + wt_extra;
    end else begin
      cost = sac_pkg::WT_COST;
    end
    if (evict) begin
      cost = cost + fill_cost;
    end
  end

  for (genvar g = 0; g < WAYS; g++) begin : g_row
    logic                      is_tgt;
    logic [sac_pkg::TAG_W-1:0] e_tag;
    logic                      e_valid;
    logic                      e_dirty;
    logic [RANK_W-1:0]         e_rank;

    assign is_tgt = (tgt_way == WAY_W'(g));

    always_comb begin
      e_tag   = ent_a[g][ENT_W-1 -: sac_pkg::TAG_W];
      e_valid = ent_a[g][VALID_B];
      e_dirty = ent_a[g][DIRTY_B];
      e_rank  = ent_a[g][RANK_W-1:0];
      if (is_tgt) begin
        if (do_fill) begin
          e_tag   = key_r;
          e_valid = 1'b1;
          e_dirty = is_store && wb_r;
        end else if (sc_hit && is_store && wb_r) begin
          e_dirty = 1'b1;
        end
        if (do_newest) begin
          e_rank = others;
        end
      end else if (do_newest && e_valid && was_valid && (e_rank > old_rank)) begin
        // lines newer than the one moved up close the gap it leaves
        e_rank = e_rank - 1'b1;
      end
    end

    assign new_row[g*ENT_W +: ENT_W] = {e_tag, e_valid, e_dirty, e_rank};
  end

  // ----------------------------------------------------------- statistics
  assign stat_upd.valid = (state_r == ST_DECIDE);
  assign stat_upd.store = kind_r;
  assign stat_upd.hit   = sc_hit;
  assign stat_upd.cost  = cost;

  sac_stats u_stats (
    .clk              (clk),
    .rst_n            (rst_n),
    .upd              (stat_upd),
    .load_cnt_r       (out_load_count),
    .store_cnt_r      (out_store_count),
    .load_hit_cnt_r   (out_load_hit_count),
    .load_miss_cnt_r  (out_load_miss_count),
    .store_hit_cnt_r  (out_store_hit_count),
    .store_miss_cnt_r (out_store_miss_count),
    .cyc_total_r      (out_cycle_total)
  );

  // -------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      way_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == SET_W'(SETS - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            set_r   <= set_full[SET_W-1:0];
            key_r   <= tag_full[sac_pkg::TAG_W-1:0];
            kind_r  <= in_kind;
            state_r <= ST_READ;
          end
        end
        ST_READ: begin
          way_cnt_r <= '0;
          state_r   <= ST_SCAN;
        end
        ST_SCAN: begin
          way_cnt_r <= way_cnt_r + 1'b1;
          if (way_cnt_r == WAY_W'(WAYS - 1)) begin
            state_r <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          out_valid_r  <= 1'b1;
          out_hit_r    <= sc_hit;
          out_evict_r  <= evict;
          out_cycles_r <= cost;
          state_r      <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign busy               = (state_r != ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_hit            = out_hit_r;
  assign out_dirty_eviction = out_evict_r;
  assign out_access_cycles  = out_cycles_r;

endmodule

>>> hdl/sac_checker.sv
// Port-level checks on the cache model, bound to the top level
`timescale 1ns / 1ps

module sac_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic                       out_valid,
  input logic                       out_hit,
  input logic                       out_dirty_eviction,
  input logic [sac_pkg::COST_W-1:0] out_access_cycles
);

  // a word is only published once the block is free again
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result word shown while busy");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted access did not raise busy");

  // a hit never replaces a line
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dirty_eviction |-> !out_hit)
    else $error("dirty eviction reported on a hit");

  // hit cost is HIT_COST, plus the write-through charge on a store
  a_hit_cost: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |->
      (out_access_cycles == sac_pkg::HIT_COST ||
       out_access_cycles == sac_pkg::HIT_COST + sac_pkg::WT_COST))
    else $error("unexpected cost on a hit");

endmodule

bind set_assoc_cache_model sac_checker u_sac_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .out_valid          (out_valid),
  .out_hit            (out_hit),
  .out_dirty_eviction (out_dirty_eviction),
  .out_access_cycles  (out_access_cycles)
);

>>> tb/set_assoc_cache_model_tb.sv
// Self-checking testbench for the set-associative cache model
`timescale 1ns / 1ps

module set_assoc_cache_model_tb;

  localparam int SETS         = 256;
  localparam int WAYS         = 4;
  localparam int NLINES       = SETS * WAYS;
  localparam int SET_LOG2_MAX = $clog2(SETS);
  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 10;
  localparam int PHASE_ITEMS  = 160;

  localparam int ADDR_W    = sac_pkg::ADDR_W;
  localparam int COST_W    = sac_pkg::COST_W;
  localparam int CNT_W     = sac_pkg::CNT_W;
  localparam int CYC_W     = sac_pkg::CYC_W;
  localparam int CFG_W     = sac_pkg::CFG_W;
  localparam int CFG_IDX_W = sac_pkg::CFG_IDX_W;

  localparam logic KIND_LOAD = ~sac_pkg::KIND_STORE;

  // running totals, in port order
  localparam int N_LOADS        = 0;
  localparam int N_STORES       = 1;
  localparam int N_LOAD_HITS    = 2;
  localparam int N_LOAD_MISSES  = 3;
  localparam int N_STORE_HITS   = 4;
  localparam int N_STORE_MISSES = 5;

  localparam logic [CNT_W-1:0] CNT_SAT = '1;
  localparam logic [CYC_W-1:0] CYC_SAT = '1;

  typedef struct packed {
    logic              hit;
    logic              dirty_ev;
    logic [COST_W-1:0] cycles;
    logic [CNT_W-1:0]  loads;
    logic [CNT_W-1:0]  stores;
    logic [CNT_W-1:0]  ld_hit_cnt;
    logic [CNT_W-1:0]  ld_miss_cnt;
    logic [CNT_W-1:0]  st_hit_cnt;
    logic [CNT_W-1:0]  st_miss_cnt;
    logic [CYC_W-1:0]  cycle_total;
  } access_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic                 in_kind;
  logic [ADDR_W-1:0]    in_address;
  logic                 out_valid;
  logic                 out_hit;
  logic                 out_dirty_eviction;
  logic [COST_W-1:0]    out_access_cycles;
  logic [CNT_W-1:0]     out_load_count;
  logic [CNT_W-1:0]     out_store_count;
  logic [CNT_W-1:0]     out_load_hit_count;
  logic [CNT_W-1:0]     out_load_miss_count;
  logic [CNT_W-1:0]     out_store_hit_count;
  logic [CNT_W-1:0]     out_store_miss_count;
  logic [CYC_W-1:0]     out_cycle_total;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  set_assoc_cache_model #(
    .SETS(SETS),
    .WAYS(WAYS)
  ) u_top (.*);

  // cache image and settings as the block should hold them
  logic [ADDR_W-1:0] way_tag   [NLINES];
  bit                way_valid [NLINES];
  bit                way_dirty [NLINES];
  int unsigned       way_rank  [NLINES];
  logic [CNT_W-1:0]  acc_totals [6];
  logic [CYC_W-1:0]  cycle_sum;
  int unsigned       blk_log2;
  int unsigned       set_log2;
  bit                lru_on;
  bit                wb_on;
  bit                walloc_on;

  access_result_t    pending_results [$];
  int                mismatches;
  bit                gaps_on;

  initial begin
    clk = 1'b0;
    forever #HALF_PERIOD clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void bump_total(int idx);
    if (acc_totals[idx] != CNT_SAT) acc_totals[idx]++;
  endfunction

  // make way w the newest line of its set
  function automatic void promote_way(int unsigned base, int unsigned w, bit was_valid);
    int unsigned old_rank;
    int unsigned others;
    old_rank = way_rank[base + w];
    others   = 0;
    for (int i = 0; i < WAYS; i++) begin
      if (i != w && way_valid[base + i]) begin
        if (was_valid && way_rank[base + i] > old_rank) way_rank[base + i]--;
        others++;
      end
    end
    way_rank[base + w] = others;
  endfunction

  // returns the write-back charge of a dirty victim
  function automatic int unsigned fill_way(int unsigned base, logic [ADDR_W-1:0] tag,
                                           bit dirty, output bit evicted);
    int unsigned w;
    int unsigned extra;
    bit          was_valid;
    w       = WAYS;
    extra   = 0;
    evicted = 1'b0;
    for (int i = WAYS - 1; i >= 0; i--)
      if (!way_valid[base + i]) w = i;
    if (w == WAYS) begin
      w = 0;
      for (int i = 1; i < WAYS; i++)
        if (way_rank[base + i] < way_rank[base + w]) w = i;
      // stale dirty lines cost nothing under write-through
      if (way_dirty[base + w] && wb_on) begin
        extra   = sac_pkg::FILL_UNIT << blk_log2;
        evicted = 1'b1;
      end
    end
    was_valid = way_valid[base + w];
    promote_way(base, w, was_valid);
    way_tag[base + w]   = tag;
    way_valid[base + w] = 1'b1;
    way_dirty[base + w] = dirty;
    return extra;
  endfunction

  function automatic void predict_access(logic kind, logic [ADDR_W-1:0] addr);
    int unsigned       fill_cost;
    int unsigned       set_idx;
    int unsigned       base;
    int unsigned       w;
    int unsigned       cost;
    logic [ADDR_W-1:0] tag;
    logic [CYC_W:0]    sum;
    bit                is_store;
    bit                hit;
    bit                evicted;
    access_result_t    r;
    is_store  = (kind == sac_pkg::KIND_STORE);
    fill_cost = sac_pkg::FILL_UNIT << blk_log2;
    set_idx   = (addr >> blk_log2) & ((1 << set_log2) - 1);
    tag       = addr >> (blk_log2 + set_log2);
    base      = set_idx * WAYS;
    evicted   = 1'b0;
    bump_total(is_store ? N_STORES : N_LOADS);
    w = WAYS;
    for (int i = WAYS - 1; i >= 0; i--)
      if (way_valid[base + i] && way_tag[base + i] == tag) w = i;
    hit = (w < WAYS);
    if (hit && lru_on) promote_way(base, w, 1'b1);
    if (!is_store) begin
      if (hit) begin
        bump_total(N_LOAD_HITS);
        cost = sac_pkg::HIT_COST;
      end else begin
        bump_total(N_LOAD_MISSES);
        cost = sac_pkg::HIT_COST + fill_cost + fill_way(base, tag, 1'b0, evicted);
      end
    end else if (hit) begin
      bump_total(N_STORE_HITS);
      cost = sac_pkg::HIT_COST;
      if (wb_on) way_dirty[base + w] = 1'b1;
      else cost += sac_pkg::WT_COST;
    end else begin
      bump_total(N_STORE_MISSES);
      if (walloc_on) begin
        cost = sac_pkg::HIT_COST + fill_cost + fill_way(base, tag, wb_on, evicted);
        if (!wb_on) cost += sac_pkg::WT_COST;
      end else begin
        cost = sac_pkg::WT_COST;
      end
    end
    sum       = cycle_sum + cost;
    cycle_sum = (sum > CYC_SAT) ? CYC_SAT : sum[CYC_W-1:0];

    r.hit          = hit;
    r.dirty_ev     = evicted;
    r.cycles       = COST_W'(cost);
    r.loads        = acc_totals[N_LOADS];
    r.stores       = acc_totals[N_STORES];
    r.ld_hit_cnt   = acc_totals[N_LOAD_HITS];
    r.ld_miss_cnt  = acc_totals[N_LOAD_MISSES];
    r.st_hit_cnt   = acc_totals[N_STORE_HITS];
    r.st_miss_cnt  = acc_totals[N_STORE_MISSES];
    r.cycle_total  = cycle_sum;
    pending_results.push_back(r);
  endfunction

  // ------------------------------------------------------------------ checker

  task automatic check_field(input string field, input logic [CYC_W-1:0] want,
                             input logic [CYC_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_check
    access_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result word with no access outstanding");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("hit", want.hit, out_hit);
        check_field("dirty_eviction", want.dirty_ev, out_dirty_eviction);
        check_field("access_cycles", want.cycles, out_access_cycles);
        check_field("load_count", want.loads, out_load_count);
        check_field("store_count", want.stores, out_store_count);
        check_field("load_hit_count", want.ld_hit_cnt, out_load_hit_count);
        check_field("load_miss_count", want.ld_miss_cnt, out_load_miss_count);
        check_field("store_hit_count", want.st_hit_cnt, out_store_hit_count);
        check_field("store_miss_count", want.st_miss_cnt, out_store_miss_count);
        check_field("cycle_total", want.cycle_total, out_cycle_total);
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  task automatic apply_reset();
    rst_n <= 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < NLINES; i++) begin
      way_tag[i]   = '0;
      way_valid[i] = 1'b0;
      way_dirty[i] = 1'b0;
      way_rank[i]  = 0;
    end
    for (int i = 0; i < 6; i++) acc_totals[i] = '0;
    cycle_sum = '0;
    blk_log2  = sac_pkg::BBL_RESET;
    set_log2  = sac_pkg::SCL_RESET;
    lru_on    = 1'b1;
    wb_on     = 1'b1;
    walloc_on = 1'b1;
  endtask

  // called and returns at a falling edge
  task automatic send_access(input logic kind, input logic [ADDR_W-1:0] addr);
    start      <= 1'b1;
    in_kind    <= kind;
    in_address <= addr;
    // hold the word until the block takes it
    do @(posedge clk); while (busy);
    predict_access(kind, addr);
    @(negedge clk);
    if (gaps_on && $urandom_range(3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(9, 1)) @(negedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  // writes all five registers once the block has gone quiet
  task automatic apply_config(input logic [CFG_W-1:0] blk, input logic [CFG_W-1:0] sets,
                              input bit lru, input bit wb, input bit walloc);
    drain();
    cfg_beat(sac_pkg::CFG_BLOCK_LOG2, blk);
    cfg_beat(sac_pkg::CFG_SET_LOG2, sets);
    cfg_beat(sac_pkg::CFG_LRU, CFG_W'(lru));
    cfg_beat(sac_pkg::CFG_WRITE_BACK, CFG_W'(wb));
    cfg_beat(sac_pkg::CFG_WRITE_ALLOC, CFG_W'(walloc));
    cfg_we <= 1'b0;
    blk_log2  = (blk < sac_pkg::BBL_MIN) ? sac_pkg::BBL_MIN :
                (blk > sac_pkg::BBL_MAX) ? sac_pkg::BBL_MAX : blk;
    set_log2  = (sets > SET_LOG2_MAX) ? SET_LOG2_MAX : sets;
    lru_on    = lru;
    wb_on     = wb;
    walloc_on = walloc;
  endtask

  // ------------------------------------------------------------------ tests

  // reset geometry: 16-byte blocks, 256 sets, so set 0 tags step by 0x1000
  task automatic test_hits_fills_and_dirty_victim();
    send_access(KIND_LOAD, 32'h0000_0000);
    send_access(KIND_LOAD, 32'h0000_0004);
    send_access(sac_pkg::KIND_STORE, 32'h0000_0008);
    send_access(sac_pkg::KIND_STORE, 32'hFFFF_FFFF);
    send_access(KIND_LOAD, 32'hFFFF_FFF0);
    send_access(KIND_LOAD, 32'h0000_1000);
    send_access(KIND_LOAD, 32'h0000_2000);
    send_access(KIND_LOAD, 32'h0000_3000);
    send_access(KIND_LOAD, 32'h0000_4000);
    send_access(sac_pkg::KIND_STORE, 32'h0000_1004);
    send_access(KIND_LOAD, 32'h0000_0000);
  endtask

  // out-of-range sizes clamp; held lines are read under the new split
  task automatic test_clamped_geometry();
    apply_config(4'd0, 4'd15, 1'b0, 1'b1, 1'b1);
    send_access(KIND_LOAD, 32'h0000_0000);
    send_access(KIND_LOAD, 32'h0000_0400);
    apply_config(4'd13, 4'd0, 1'b0, 1'b1, 1'b0);
    send_access(sac_pkg::KIND_STORE, 32'h8000_0123);
    send_access(KIND_LOAD, 32'hFFFF_FFFF);
    send_access(KIND_LOAD, 32'h0000_0000);
  endtask

  // dirty lines from write-back mode evicted later under write-through
  task automatic test_write_through_over_dirty();
    apply_config(4'd4, 4'd9, 1'b1, 1'b1, 1'b1);
    for (int t = 1; t <= 4; t++) send_access(sac_pkg::KIND_STORE, (t << 12) | 32'h50);
    apply_config(4'd4, 4'd8, 1'b1, 1'b0, 1'b1);
    for (int t = 5; t <= 8; t++) send_access(KIND_LOAD, (t << 12) | 32'h50);
    send_access(sac_pkg::KIND_STORE, 32'h0000_8054);
    send_access(sac_pkg::KIND_STORE, 32'h0000_9050);
  endtask

  // most words hit a few hot sets so that lines are reused and evicted
  task automatic run_traffic_phase(input int n_items);
    logic [ADDR_W-1:0] hot_addr [16];
    int unsigned       hot_sets [3];
    logic [ADDR_W-1:0] addr;
    for (int i = 0; i < 3; i++) hot_sets[i] = $urandom & ((1 << set_log2) - 1);
    for (int i = 0; i < 16; i++)
      hot_addr[i] = ($urandom << (blk_log2 + set_log2)) | (hot_sets[i % 3] << blk_log2);
    for (int k = 0; k < n_items; k++) begin
      if ($urandom_range(9) < 8)
        addr = hot_addr[$urandom_range(15)] | ($urandom & ((1 << blk_log2) - 1));
      else
        addr = $urandom;
      send_access($urandom_range(1) ? sac_pkg::KIND_STORE : KIND_LOAD, addr);
    end
  endtask

  task automatic random_config();
    apply_config(CFG_W'($urandom_range(15)), CFG_W'($urandom_range(15)),
                 bit'($urandom_range(1)), bit'($urandom_range(1)),
                 bit'($urandom_range(1)));
  endtask

  task automatic test_random_traffic();
    gaps_on = 1'b1;
    // smallest and largest geometry first, then a spread of settings
    apply_config(sac_pkg::BBL_MIN, 4'd0, 1'b1, 1'b1, 1'b1);
    run_traffic_phase(PHASE_ITEMS);
    apply_config(sac_pkg::BBL_MAX, CFG_W'(SET_LOG2_MAX), 1'b0, 1'b0, 1'b0);
    run_traffic_phase(PHASE_ITEMS);
    for (int p = 0; p < 8; p++) begin
      random_config();
      run_traffic_phase(PHASE_ITEMS);
    end
  endtask

  task automatic test_back_to_back();
    gaps_on = 1'b0;
    for (int p = 0; p < 2; p++) begin
      random_config();
      run_traffic_phase(PHASE_ITEMS);
    end
  endtask

  initial begin
    start      <= 1'b0;
    in_kind    <= KIND_LOAD;
    in_address <= '0;
    cfg_we     <= 1'b0;
    cfg_index  <= sac_pkg::CFG_BLOCK_LOG2;
    cfg_data   <= '0;
    mismatches = 0;
    gaps_on    = 1'b1;

    apply_reset();
    test_hits_fills_and_dirty_victim();
    test_clamped_geometry();
    test_write_through_over_dirty();
    test_random_traffic();
    test_back_to_back();

    drain();
    repeat (2 * (WAYS + 3)) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
